// ===== hw/rtl/mlam_pkg.sv =====
// ----------------------------------------------------------------------------
// mlam_pkg
// shared types, codes and constant tables of the mesh link airtime metric table
// ----------------------------------------------------------------------------
`default_nettype none

package mlam_pkg;

  localparam int ADDR_W   = 48;
  localparam int TPUT_W   = 20;
  localparam int RATE_W   = 14;
  localparam int QUO_W    = 25;
  localparam int METRIC_W = 17;
  localparam int SMS_W    = 7;

  // reciprocal of 100 scaled by 2^27, exact for any 20-bit numerator
  localparam int RECIP_SHIFT = 27;
  localparam logic [20:0] RECIP_100 = 21'd1342178;

  localparam logic [QUO_W-1:0] AIRTIME_NUM = 25'd20971520;
  localparam logic [30:0] BIG_METRIC = 31'h7fffffff;

  // configuration register indexes
  localparam logic [1:0] REG_EWMA_SHIFT = 2'd0;
  localparam logic [1:0] REG_HYST_SHIFT = 2'd1;
  localparam logic [1:0] REG_BASE_RATE  = 2'd2;
  localparam logic [1:0] REG_RSSI_W     = 2'd3;

  // result status codes
  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_SKIPPED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_QUERY   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] station_addr;
    logic [TPUT_W-1:0] expected_throughput;
    logic [RATE_W-1:0] rate_div;
    logic [SMS_W-1:0]  sig_metric;
    logic              sig_unknown;
    logic              skip;
  } item_t;

  typedef struct packed {
    logic [3:0] ewma_shift;
    logic [4:0] hysteresis_shift;
    logic [8:0] rssi_weight_q8;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN, B_BL1, B_BL2, B_RD, B_RDW, B_UPD, B_QRY1, B_QRY2, B_WR, B_RES
  } back_state_t;

  // signal strength to airtime: 8192 / rate for the ten-step rate ladder
  function automatic logic [SMS_W-1:0] sig_airtime(input logic signed [7:0] s);
    logic [SMS_W-1:0] m;
    begin
      if (s >= -8'sd51)      m = 7'd9;
      else if (s >= -8'sd53) m = 7'd10;
      else if (s >= -8'sd58) m = 7'd12;
      else if (s >= -8'sd59) m = 7'd14;
      else if (s >= -8'sd60) m = 7'd15;
      else if (s >= -8'sd64) m = 7'd21;
      else if (s >= -8'sd68) m = 7'd31;
      else if (s >= -8'sd71) m = 7'd42;
      else if (s >= -8'sd73) m = 7'd63;
      else                   m = 7'd126;
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mlam_front.sv =====
// ----------------------------------------------------------------------------
// mlam_front
// accepts words, classifies them and derives the rate divisor
// ----------------------------------------------------------------------------
`default_nettype none

module mlam_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic [47:0]                 in_addr,
  input  wire logic [19:0]                 in_tput,
  input  wire logic [7:0]                  in_sig,
  input  wire logic [19:0]                 base_rate,
  output logic                             push,
  output mlam_pkg::item_t                  push_item,
  input  wire logic                        q_full
);
  import mlam_pkg::*;

  logic              full;
  logic              kind;
  logic [ADDR_W-1:0] addr;
  logic [TPUT_W-1:0] tput;
  logic [40:0]       prod;
  logic [SMS_W-1:0]  sms;
  logic              sunk;
  logic              skip;

  assign in_ready = !full;
  assign push     = full && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (push) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind <= in_kind;
      addr <= in_addr;
      tput <= in_tput;
      // (t - 1) / 100 by reciprocal multiply
      prod <= {21'd0, in_tput - 20'd1} * {20'd0, RECIP_100};
      sms  <= sig_airtime(in_sig);
      sunk <= (in_sig == 8'd0);
      skip <= (in_kind == KIND_SAMPLE) && ((in_tput == 20'd0) || (in_tput == base_rate));
    end
  end

  always_comb begin
    push_item.kind                = kind;
    push_item.station_addr        = addr;
    push_item.expected_throughput = tput;
    push_item.rate_div            = prod[RECIP_SHIFT +: RATE_W] + RATE_W'(1);
    push_item.sig_metric          = sms;
    push_item.sig_unknown         = sunk;
    push_item.skip                = skip;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlam_fifo.sv =====
// ----------------------------------------------------------------------------
// mlam_fifo
// two-entry queue between classifier and table engine
// ----------------------------------------------------------------------------
`default_nettype none

module mlam_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  mlam_pkg::item_t       push_item,
  output logic                  full,
  output logic                  valid,
  output mlam_pkg::item_t       head,
  input  wire logic             pop
);
  import mlam_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlam_div.sv =====
// ----------------------------------------------------------------------------
// mlam_div
// restoring divider, constant numerator over the rate divisor, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mlam_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [mlam_pkg::RATE_W-1:0]       divisor,
  output logic                                   done,
  output logic [mlam_pkg::QUO_W-1:0]             quotient
);
  import mlam_pkg::*;

  logic [RATE_W-1:0] dv;
  logic [RATE_W-1:0] rem;
  logic [QUO_W-1:0]  num;
  logic [4:0]        cnt;
  logic [RATE_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem, num[QUO_W-1]};
  assign ge     = (rem_sh >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      done     <= 1'b0;
      cnt      <= 5'(QUO_W);
      dv       <= divisor;
      rem      <= '0;
      num      <= AIRTIME_NUM;
      quotient <= '0;
    end else if (cnt != 5'd0) begin
      rem      <= ge ? RATE_W'(rem_sh - {1'b0, dv}) : rem_sh[RATE_W-1:0];
      num      <= {num[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], ge};
      cnt      <= cnt - 5'd1;
      if (cnt == 5'd1) done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlam_back.sv =====
// ----------------------------------------------------------------------------
// mlam_back
// table engine: station search, blend, average update, query and result word
// ----------------------------------------------------------------------------
`default_nettype none

module mlam_back #(
  parameter int STATIONS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  mlam_pkg::cfg_t       cfg,
  input  wire logic            q_valid,
  input  mlam_pkg::item_t      q_head,
  output logic                 q_pop,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic [2:0]           res_status,
  output logic [30:0]          res_metric
);
  import mlam_pkg::*;

  localparam int SLOT_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int CNT_W  = $clog2(STATIONS + 1);

  back_state_t state, state_next;

  // table storage
  logic [STATIONS-1:0] valid;
  logic [ADDR_W-1:0]   addr_mem [STATIONS];
  logic [31:0]         ewma_mem [STATIONS];
  logic [31:0]         rep_mem  [STATIONS];
  logic [3:0]          cnt_mem  [STATIONS];
  logic [ADDR_W-1:0]   addr_q;
  logic [31:0]         ewma_q;
  logic [31:0]         rep_q;
  logic [3:0]          cnt_q;

  item_t               it;
  logic [CNT_W-1:0]    scan_idx;
  logic                cmp_vld;
  logic [SLOT_W-1:0]   cmp_idx;
  logic                scan_done;
  logic                found;
  logic [SLOT_W-1:0]   found_idx;
  logic                freef;
  logic [SLOT_W-1:0]   free_idx;
  logic [SLOT_W-1:0]   slot;
  logic                is_new;

  logic                div_start;
  logic                div_done;
  logic [QUO_W-1:0]    quo;
  logic [METRIC_W-1:0] mb;
  logic [METRIC_W-1:0] ms_eff;
  logic [8:0]          w;
  logic [25:0]         p1;
  logic [METRIC_W-1:0] blend;
  logic [31:0]         ewma;
  logic [31:0]         rep;
  logic [31:0]         hyst;
  logic [3:0]          cnt;
  logic [3:0]          upd_left;
  logic [31:0]         rep_sh;
  logic                res_load;
  logic                write_en;
  logic                out_free;

  logic [25:0]         mb_sum;
  logic [26:0]         p2;

  // result register free, or emptied at this edge
  assign out_free = !res_valid || res_ready;

  assign mb_sum = 26'(quo) + 26'd256;
  assign mb     = mb_sum[24:8];
  assign ms_eff = it.sig_unknown ? mb : METRIC_W'(it.sig_metric);
  assign w      = (cfg.rssi_weight_q8 > 9'd256) ? 9'd256 : cfg.rssi_weight_q8;
  assign p2     = {1'b0, p1} + ({18'd0, w} * {10'd0, ms_eff}) + 27'd128;
  assign rep_sh = rep >> cfg.ewma_shift;

  mlam_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (q_head.rate_div),
    .done     (div_done),
    .quotient (quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid && out_free) state_next = q_head.skip ? B_RES : B_SCAN;
      B_SCAN: begin
        if (scan_done && div_done) begin
          if (it.kind == KIND_SAMPLE) state_next = (found || freef) ? B_BL1 : B_RES;
          else                        state_next = found ? B_RD : B_RES;
        end
      end
      B_BL1:  state_next = B_BL2;
      B_BL2:  state_next = B_RD;
      B_RD:   state_next = B_RDW;
      B_RDW:  state_next = (it.kind == KIND_SAMPLE) ? B_UPD : B_QRY1;
      B_UPD:  if (upd_left == 4'd1) state_next = B_WR;
      B_QRY1: state_next = B_QRY2;
      B_QRY2: state_next = B_WR;
      B_WR:   state_next = B_RES;
      B_RES:  if (res_load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    write_en  = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_pop     = q_valid && out_free;
        div_start = q_valid && out_free && !q_head.skip;
      end
      B_WR:   write_en = 1'b1;
      B_RES:  res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // search over the address memory, one slot a cycle with a registered read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scan_idx  <= '0;
      cmp_vld   <= 1'b0;
      scan_done <= 1'b0;
      found     <= 1'b0;
      freef     <= 1'b0;
    end else if (state == B_SCAN) begin
      if (scan_idx < CNT_W'(STATIONS)) begin
        addr_q   <= addr_mem[scan_idx[SLOT_W-1:0]];
        cmp_idx  <= scan_idx[SLOT_W-1:0];
        cmp_vld  <= 1'b1;
        scan_idx <= scan_idx + CNT_W'(1);
      end else begin
        cmp_vld <= 1'b0;
      end
      if (cmp_vld) begin
        if (valid[cmp_idx] && addr_q == it.station_addr && !found) begin
          found     <= 1'b1;
          found_idx <= cmp_idx;
        end
        if (!valid[cmp_idx] && !freef) begin
          freef    <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (cmp_idx == SLOT_W'(STATIONS - 1)) scan_done <= 1'b1;
      end
    end
  end

  // entry memories
  always_ff @(posedge clk) begin
    ewma_q <= ewma_mem[slot];
    rep_q  <= rep_mem[slot];
    cnt_q  <= cnt_mem[slot];
    if (write_en) begin
      ewma_mem[slot] <= ewma;
      rep_mem[slot]  <= rep;
      cnt_mem[slot]  <= cnt;
      if (is_new) addr_mem[slot] <= it.station_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (write_en && is_new) begin
      valid[slot] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid && out_free) begin
          it         <= q_head;
          res_status <= ST_SKIPPED;
          res_metric <= '0;
        end
      end
      B_SCAN: begin
        if (scan_done && div_done) begin
          slot   <= found ? found_idx : free_idx;
          is_new <= !found;
          if (it.kind == KIND_SAMPLE) begin
            res_status <= (found || freef) ? ST_APPLIED : ST_FULL;
          end else if (!found) begin
            res_status <= ST_UNKNOWN;
            res_metric <= (it.expected_throughput == '0) ? BIG_METRIC : 31'(mb);
          end
        end
      end
      B_BL1:  p1 <= {17'd0, 9'd256 - w} * {9'd0, mb};
      B_BL2:  blend <= p2[24:8];
      B_RDW: begin
        if (it.kind == KIND_SAMPLE && is_new) begin
          ewma     <= 32'({15'd0, blend} << cfg.ewma_shift);
          rep      <= '0;
          cnt      <= 4'd1;
          upd_left <= 4'd11;
        end else if (it.kind == KIND_SAMPLE) begin
          ewma     <= ewma_q;
          rep      <= rep_q;
          cnt      <= (cnt_q < 4'd10) ? cnt_q + 4'd1 : cnt_q;
          upd_left <= (cnt_q < 4'd10) ? 4'd11 - cnt_q : 4'd1;
        end else begin
          ewma <= ewma_q;
          rep  <= rep_q;
          cnt  <= cnt_q;
        end
      end
      B_UPD: begin
        ewma     <= ewma + 32'(blend) - (ewma >> cfg.ewma_shift);
        upd_left <= upd_left - 4'd1;
      end
      B_QRY1: begin
        rep  <= (rep == '0) ? ewma : rep;
        hyst <= ((rep == '0) ? ewma : rep) >> cfg.hysteresis_shift;
      end
      B_QRY2: begin
        if (ewma > rep + hyst || ewma < rep - hyst) rep <= ewma;
      end
      B_WR: begin
        if (it.kind != KIND_SAMPLE) begin
          res_status <= ST_QUERY;
          res_metric <= rep_sh[31] ? BIG_METRIC : rep_sh[30:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_link_airtime_metric_table.sv =====
// ----------------------------------------------------------------------------
// mesh_link_airtime_metric_table
// per-station smoothed airtime link metric with sample and query words
// ----------------------------------------------------------------------------
// flow: a skipped sample goes straight to the result; a table sample runs the search
//   (one slot a cycle, divider overlapped), blend, read and up to eleven average steps;
//   a query runs search, read and hysteresis; an unknown station or full table stops
//   after the search; the divider runs under the search and only sets the pace below 24 slots
// throughput: one word at a time in the table engine, set by the slot search loop;
//   a new word enters the engine only once the previous result word is taken
// reset: synchronous; clears all valid bits and restores register defaults at once
`default_nettype none

module mesh_link_airtime_metric_table #(
  parameter int STATIONS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // station_addr[47:0], expected_throughput[67:48],
                                           // signal_dbm[75:68], zero fill
  input  wire logic        s_axis_tuser,   // kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // link_metric[30:0], zero fill
  output logic [2:0]       m_axis_tuser,   // status
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mlam_pkg::*;

  logic [3:0]  ewma_shift;
  logic [4:0]  hysteresis_shift;
  logic [19:0] base_rate;
  logic [8:0]  rssi_weight_q8;
  cfg_t        cfg;

  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        q_valid;
  item_t       q_head;
  logic        q_pop;
  logic [30:0] metric;

  assign pready = 1'b1;

  // register writes land on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_shift       <= 4'd4;
      hysteresis_shift <= 5'd4;
      base_rate        <= 20'd60;
      rssi_weight_q8   <= 9'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_EWMA_SHIFT: ewma_shift       <= pwdata[3:0];
        REG_HYST_SHIFT: hysteresis_shift <= pwdata[4:0];
        REG_BASE_RATE:  base_rate        <= pwdata[19:0];
        REG_RSSI_W:     rssi_weight_q8   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EWMA_SHIFT: prdata = {28'd0, ewma_shift};
      REG_HYST_SHIFT: prdata = {27'd0, hysteresis_shift};
      REG_BASE_RATE:  prdata = {12'd0, base_rate};
      REG_RSSI_W:     prdata = {23'd0, rssi_weight_q8};
      default:        prdata = '0;
    endcase
  end

  assign cfg.ewma_shift       = ewma_shift;
  assign cfg.hysteresis_shift = hysteresis_shift;
  assign cfg.rssi_weight_q8   = rssi_weight_q8;

  // classifier: skip test, signal table and divisor of the rate
  mlam_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_addr   (s_axis_tdata[47:0]),
    .in_tput   (s_axis_tdata[67:48]),
    .in_sig    (s_axis_tdata[75:68]),
    .base_rate (base_rate),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  mlam_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  // table engine with its own output register
  mlam_back #(
    .STATIONS (STATIONS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_status (m_axis_tuser),
    .res_metric (metric)
  );

  assign m_axis_tdata = {1'b0, metric};

  // status codes stay in their defined range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= ST_UNKNOWN))
    else $error("result status out of range");

  // sample results carry no metric
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_APPLIED || m_axis_tuser == ST_SKIPPED ||
                      m_axis_tuser == ST_FULL) |-> (m_axis_tdata == 32'd0))
    else $error("sample result with nonzero metric");

  // the queue never takes a word while full
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overrun");

endmodule

`default_nettype wire
